// ----- sv/dd4s_pkg.sv -----
// ----------------------------------------------------------------------------
// dd4s_pkg: shared types and constants for the digit-dash-four-digit scanner
// Window length, ASCII codes, cell output type and digit helpers.
// ----------------------------------------------------------------------------
package dd4s_pkg;

    localparam int unsigned WINDOW_LEN   = 5;
    localparam int unsigned CNT_W        = $clog2(WINDOW_LEN + 1);
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned DIGIT_W      = 4;
    localparam int unsigned SERIAL_W     = 14;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_DASH = 8'h2D;

    // What each window cell presents to the match logic
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_digit;
        logic              is_dash;
    } cell_t;

    function automatic logic byte_is_digit(input logic [BYTE_W-1:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    // Valid only for digit bytes: the low nibble of '0'..'9' is the value
    function automatic logic [DIGIT_W-1:0] digit_val(input logic [BYTE_W-1:0] b);
        return b[DIGIT_W-1:0];
    endfunction

endpackage

// ----- sv/digit_dash_four_digit_scanner.sv -----
// ----------------------------------------------------------------------------
// digit_dash_four_digit_scanner: finds D-DDDD in a byte stream
//
//   channel | direction | fields                          | handshake
//   s_      | in        | data_byte[7:0], stream_start    | s_valid / s_ready
//   m_      | out       | prefix_digit[3:0], serial_value | m_valid / m_ready
//
// One byte per clock while s_ready is high. A byte enters the chain of window
// cells on acceptance; a match is decided and converted in that same cycle, then
// registered in the output register or its skid slot. s_ready is registered
// and drops only when both the output register and its skid slot hold results.
// Reset (aresetn, synchronous) clears window, fresh-byte count, both result slots.
// ----------------------------------------------------------------------------
module digit_dash_four_digit_scanner (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dd4s_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            s_stream_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dd4s_pkg::DIGIT_W-1:0]    m_prefix_digit,
    output logic [dd4s_pkg::SERIAL_W-1:0]   m_serial_value
);

    localparam int unsigned N = dd4s_pkg::WINDOW_LEN;

    dd4s_pkg::cell_t              cells [N];
    logic                         take;
    logic                         hit;
    logic [dd4s_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [dd4s_pkg::SERIAL_W-1:0] serial;
    logic [dd4s_pkg::SERIAL_W-1:0] d_thou, d_hund, d_ten, d_one;

    assign take = s_valid && s_ready;

    // Cell N-1 takes the new byte; the others take their newer neighbor.
    // A stream start zeroes every older slot before the byte goes in.
    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == N - 1) begin : g_head
            dd4s_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (take),
                .clear    (1'b0),
                .data_in  (s_data_byte),
                .cell_out (cells[i])
            );
        end else begin : g_body
            dd4s_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (take),
                .clear    (s_stream_start),
                .data_in  (cells[i+1].data),
                .cell_out (cells[i])
            );
        end
    end

    assign hit = !s_stream_start
              && (count_reg == dd4s_pkg::CNT_W'(N))
              && cells[0].is_digit && cells[1].is_dash
              && cells[2].is_digit && cells[3].is_digit && cells[4].is_digit
              && dd4s_pkg::byte_is_digit(s_data_byte);

    always_comb begin
        d_thou = dd4s_pkg::SERIAL_W'(dd4s_pkg::digit_val(cells[2].data));
        d_hund = dd4s_pkg::SERIAL_W'(dd4s_pkg::digit_val(cells[3].data));
        d_ten  = dd4s_pkg::SERIAL_W'(dd4s_pkg::digit_val(cells[4].data));
        d_one  = dd4s_pkg::SERIAL_W'(dd4s_pkg::digit_val(s_data_byte));
        serial = d_thou * dd4s_pkg::SERIAL_W'(1000) + d_hund * dd4s_pkg::SERIAL_W'(100)
               + d_ten * dd4s_pkg::SERIAL_W'(10) + d_one;
    end

    always_comb begin
        count_next = count_reg;
        if (take) begin
            if (hit) begin
                count_next = '0;
            end else if (s_stream_start) begin
                count_next = dd4s_pkg::CNT_W'(1);
            end else if (count_reg < dd4s_pkg::CNT_W'(N)) begin
                count_next = count_reg + dd4s_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    dd4s_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (take && hit),
        .push_prefix    (dd4s_pkg::digit_val(cells[0].data)),
        .push_serial    (serial),
        .can_accept     (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prefix_digit (m_prefix_digit),
        .m_serial_value (m_serial_value)
    );

endmodule

// ----- sv/dd4s_cell.sv -----
// ----------------------------------------------------------------------------
// dd4s_cell: one byte slot of the scan window
// Loads data_in (its neighbor's byte, or the new byte at the head) on every accepted transaction, zero on clear,
// and keeps the digit and dash flags alongside the byte.
// ----------------------------------------------------------------------------
module dd4s_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic                          clear,
    input  logic [dd4s_pkg::BYTE_W-1:0]   data_in,
    output dd4s_pkg::cell_t               cell_out
);

    dd4s_pkg::cell_t cell_reg;
    dd4s_pkg::cell_t cell_next;
    logic [dd4s_pkg::BYTE_W-1:0] load_byte;

    always_comb begin
        load_byte          = clear ? '0 : data_in;
        cell_next          = cell_reg;
        if (shift_en) begin
            cell_next.data     = load_byte;
            cell_next.is_digit = dd4s_pkg::byte_is_digit(load_byte);
            cell_next.is_dash  = (load_byte == dd4s_pkg::ASCII_DASH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- sv/dd4s_out.sv -----
// ----------------------------------------------------------------------------
// dd4s_out: output register with skid slot
// Holds match results toward the m_ side; ready upstream is registered.
// ----------------------------------------------------------------------------
module dd4s_out (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  logic [dd4s_pkg::DIGIT_W-1:0]    push_prefix,
    input  logic [dd4s_pkg::SERIAL_W-1:0]   push_serial,
    output logic                            can_accept,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dd4s_pkg::DIGIT_W-1:0]    m_prefix_digit,
    output logic [dd4s_pkg::SERIAL_W-1:0]   m_serial_value
);

    logic                            main_valid_reg, main_valid_next;
    logic [dd4s_pkg::DIGIT_W-1:0]    main_prefix_reg, main_prefix_next;
    logic [dd4s_pkg::SERIAL_W-1:0]   main_serial_reg, main_serial_next;
    logic                            skid_valid_reg, skid_valid_next;
    logic [dd4s_pkg::DIGIT_W-1:0]    skid_prefix_reg, skid_prefix_next;
    logic [dd4s_pkg::SERIAL_W-1:0]   skid_serial_reg, skid_serial_next;

    always_comb begin
        main_valid_next  = main_valid_reg;
        main_prefix_next = main_prefix_reg;
        main_serial_next = main_serial_reg;
        skid_valid_next  = skid_valid_reg;
        skid_prefix_next = skid_prefix_reg;
        skid_serial_next = skid_serial_reg;
        if (!main_valid_reg || m_ready) begin
            // main slot is free this cycle; push never coincides with a full skid
            if (skid_valid_reg) begin
                main_valid_next  = 1'b1;
                main_prefix_next = skid_prefix_reg;
                main_serial_next = skid_serial_reg;
                skid_valid_next  = 1'b0;
            end else begin
                main_valid_next  = push;
                main_prefix_next = push_prefix;
                main_serial_next = push_serial;
            end
        end else if (push) begin
            skid_valid_next  = 1'b1;
            skid_prefix_next = push_prefix;
            skid_serial_next = push_serial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_prefix_reg <= main_prefix_next;
        main_serial_reg <= main_serial_next;
        skid_prefix_reg <= skid_prefix_next;
        skid_serial_reg <= skid_serial_next;
    end

    assign can_accept     = !skid_valid_reg;
    assign m_valid        = main_valid_reg;
    assign m_prefix_digit = main_prefix_reg;
    assign m_serial_value = main_serial_reg;

endmodule

// ----- tb/digit_dash_four_digit_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// digit_dash_four_digit_scanner_tb: self-checking bench for the D-DDDD scanner
// Feeds byte streams of well-formed, near-miss and noise patterns through the
// s_ channel and checks every m_ result against an in-bench scanner model.
// Both sides idle at random; one phase swaps the idle rates, one has none.
// ----------------------------------------------------------------------------
module digit_dash_four_digit_scanner_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [dd4s_pkg::BYTE_W-1:0] data;
        logic                        start;
        bit                          drain_first;   // hold off until all results are in
    } scan_byte_t;

    typedef struct {
        logic [dd4s_pkg::DIGIT_W-1:0]  prefix;
        logic [dd4s_pkg::SERIAL_W-1:0] serial;
    } serial_hit_t;

    logic                            aclk;
    logic                            aresetn        = 1'b0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [dd4s_pkg::BYTE_W-1:0]     s_data_byte    = '0;
    logic                            s_stream_start = 1'b0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [dd4s_pkg::DIGIT_W-1:0]    m_prefix_digit;
    logic [dd4s_pkg::SERIAL_W-1:0]   m_serial_value;

    scan_byte_t  tx_bytes[$];
    serial_hit_t serial_hits[$];
    int          bytes_queued   = 0;
    int          bytes_taken    = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    int          source_gap_pct = 0;
    int          sink_stall_pct = 0;
    logic        byte_taken     = 1'b0;

    // scanner state as the block should hold it
    logic [dd4s_pkg::BYTE_W-1:0] win [dd4s_pkg::WINDOW_LEN];
    logic [dd4s_pkg::CNT_W-1:0]  fresh;

    digit_dash_four_digit_scanner uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_stream_start (s_stream_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prefix_digit (m_prefix_digit),
        .m_serial_value (m_serial_value)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit is_num(input logic [dd4s_pkg::BYTE_W-1:0] b);
        return (b >= dd4s_pkg::ASCII_ZERO) && (b <= dd4s_pkg::ASCII_NINE);
    endfunction

    function automatic int num_of(input logic [dd4s_pkg::BYTE_W-1:0] b);
        return int'(b) - int'(dd4s_pkg::ASCII_ZERO);
    endfunction

    // Shifts one byte into the window; returns 1 when it completes D-DDDD
    function automatic bit scan_byte(input logic [dd4s_pkg::BYTE_W-1:0] b,
                                     input logic start,
                                     output logic [dd4s_pkg::DIGIT_W-1:0] pfx,
                                     output logic [dd4s_pkg::SERIAL_W-1:0] ser);
        bit hit;
        if (start) begin
            foreach (win[i]) win[i] = '0;
            fresh = '0;
        end
        hit = (fresh == dd4s_pkg::WINDOW_LEN) && is_num(win[0]) &&
              (win[1] == dd4s_pkg::ASCII_DASH) &&
              is_num(win[2]) && is_num(win[3]) && is_num(win[4]) && is_num(b);
        pfx = '0;
        ser = '0;
        if (hit) begin
            pfx = dd4s_pkg::DIGIT_W'(num_of(win[0]));
            ser = dd4s_pkg::SERIAL_W'(num_of(win[2]) * 1000 + num_of(win[3]) * 100 +
                                      num_of(win[4]) * 10 + num_of(b));
        end
        for (int i = 0; i < dd4s_pkg::WINDOW_LEN - 1; i++) win[i] = win[i+1];
        win[dd4s_pkg::WINDOW_LEN-1] = b;
        if (hit)
            fresh = '0;
        else if (fresh < dd4s_pkg::WINDOW_LEN)
            fresh = fresh + 1'b1;
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int due);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, due);
        mismatches++;
    endtask

    task automatic push_byte(input logic [dd4s_pkg::BYTE_W-1:0] b, input logic start,
                             input bit drain_first);
        scan_byte_t item;
        item.data        = b;
        item.start       = start;
        item.drain_first = drain_first;
        tx_bytes.push_back(item);
        bytes_queued++;
    endtask

    task automatic push_text(input string s, input logic start_first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], start_first && (i == 0), 1'b0);
    endtask

    function automatic logic [dd4s_pkg::BYTE_W-1:0] rand_digit();
        return dd4s_pkg::ASCII_ZERO + dd4s_pkg::BYTE_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [dd4s_pkg::BYTE_W-1:0] any_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return rand_digit();
        else if (pick < 55)
            return dd4s_pkg::ASCII_DASH;
        else
            return dd4s_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // Bytes that sit just outside what a pattern slot accepts
    function automatic logic [dd4s_pkg::BYTE_W-1:0] near_miss(input bit dash_slot);
        case ($urandom_range(0, 5))
            0: return dash_slot ? rand_digit() : 8'h2F;
            1: return dash_slot ? 8'h2C : 8'h3A;
            2: return dash_slot ? 8'h2E : (rand_digit() | 8'h80);
            3: return dash_slot ? 8'hAD : dd4s_pkg::ASCII_DASH;
            4: return dash_slot ? 8'h3D : (rand_digit() ^ 8'h40);
            default: return dd4s_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic load_random(input int n);
        int                          target;
        int                          kind;
        int                          spot;
        logic [dd4s_pkg::BYTE_W-1:0] pat [6];
        logic                        starts [6];
        target = bytes_queued + n;
        push_byte(any_byte(), 1'b0, 1'b1);
        while (bytes_queued < target) begin
            kind = $urandom_range(0, 99);
            repeat ($urandom_range(0, 2))
                push_byte(any_byte(), $urandom_range(0, 29) == 0, 1'b0);
            if (kind < 85) begin
                pat[0] = rand_digit();
                pat[1] = dd4s_pkg::ASCII_DASH;
                for (int i = 2; i < 6; i++) pat[i] = rand_digit();
                foreach (starts[i]) starts[i] = 1'b0;
                starts[0] = ($urandom_range(0, 4) == 0);
                if (kind >= 65) begin
                    // broken pattern: a bad byte or a stream restart inside it
                    spot = $urandom_range(0, 5);
                    if ($urandom_range(0, 2) == 0 && spot != 0)
                        starts[spot] = 1'b1;
                    else
                        pat[spot] = near_miss(spot == 1);
                end
                for (int i = 0; i < 6; i++)
                    push_byte(pat[i], starts[i], 1'b0);
            end else begin
                repeat ($urandom_range(1, 8))
                    push_byte(dd4s_pkg::BYTE_W'($urandom_range(0, 255)),
                              $urandom_range(0, 19) == 0,
                              $urandom_range(0, 199) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || serial_hits.size() != 0)
            @(posedge aclk);
    endtask

    // driver: new transaction or idle at the falling edge
    always @(negedge aclk) begin : drive
        scan_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (!s_valid || byte_taken) begin
                if (tx_bytes.size() != 0 &&
                    !(tx_bytes[0].drain_first && serial_hits.size() != 0) &&
                    $urandom_range(0, 99) >= source_gap_pct) begin
                    nxt = tx_bytes.pop_front();
                    s_valid        <= 1'b1;
                    s_data_byte    <= nxt.data;
                    s_stream_start <= nxt.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results first, then predict from the byte taken this edge
    always @(posedge aclk) begin : monitor
        logic [dd4s_pkg::DIGIT_W-1:0]  pfx;
        logic [dd4s_pkg::SERIAL_W-1:0] ser;
        serial_hit_t                   due;
        if (!aresetn) begin
            byte_taken   <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            byte_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (serial_hits.size() == 0) begin
                    report_mismatch("unexpected result, prefix", int'(m_prefix_digit), -1);
                end else begin
                    due = serial_hits.pop_front();
                    if (m_prefix_digit !== due.prefix)
                        report_mismatch("prefix_digit", int'(m_prefix_digit), int'(due.prefix));
                    if (m_serial_value !== due.serial)
                        report_mismatch("serial_value", int'(m_serial_value), int'(due.serial));
                end
            end
            if (s_valid && s_ready) begin
                bytes_taken++;
                if (scan_byte(s_data_byte, s_stream_start, pfx, ser)) begin
                    due.prefix = pfx;
                    due.serial = ser;
                    serial_hits.push_back(due);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("digit_dash_four_digit_scanner regression: fail");
        $finish;
    end

    initial begin : stimulus
        foreach (win[i]) win[i] = '0;
        fresh = '0;
        aresetn = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        source_gap_pct = 17;
        sink_stall_pct = 46;
        push_text("0-0000", 1'b1);       // match right at stream start, lowest values
        push_text("-1234", 1'b0);        // would reuse the last digit: no match
        push_text("9-9999", 1'b0);       // highest values
        push_byte("8", 1'b0, 1'b0);
        push_text("-1234", 1'b1);        // restart drops the leading digit
        push_byte(8'h2F, 1'b0, 1'b0);
        push_byte(8'h3A, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        load_random(410);
        wait_drained();

        source_gap_pct = 46;
        sink_stall_pct = 17;
        load_random(410);
        wait_drained();

        source_gap_pct = 0;
        sink_stall_pct = 0;
        load_random(410);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("digit_dash_four_digit_scanner regression: pass");
        else
            $display("digit_dash_four_digit_scanner regression: fail");
        $finish;
    end

endmodule
